[src/prle_pkg.sv]
// prle_pkg: types, constants and helpers shared by the planar rle plane decoder
// no dependencies

package prle_pkg;

  localparam int CODE_W     = 8;
  localparam int PIX_W      = 8;
  localparam int COL_OUT_W  = 11;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int RAW_W      = 4;
  localparam int REP_W      = 6;
  localparam int MAX_HEIGHT = 4096;

  // register index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // low nibble values that turn a control byte into a long repeat
  localparam logic [3:0] LONG_REP_16 = 4'h1;
  localparam logic [3:0] LONG_REP_32 = 4'h2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } prle_state_t;

  // odd codes are negative: x -> -(x/2+1), even codes x -> x/2
  function automatic logic [PIX_W-1:0] delta_decode(input logic [CODE_W-1:0] b);
    logic [PIX_W-1:0] half;
    half = {1'b0, b[CODE_W-1:1]};
    return b[0] ? ~half : half;
  endfunction

endpackage

[src/planar_rle_plane_decoder.sv]
// planar_rle_plane_decoder: rle plane decoder of the planar bitmap codec
// depends on prle_pkg; holds the line store memory and the pixel sequencer
//
// usage:
//   in_*  : one compressed byte per item (in_tdata = code_byte)
//   out_* : one decoded pixel per item; tdata = {buffer_row, column, pixel_value},
//           tlast marks the last pixel caused by one input byte, tuser the last
//           pixel of the plane
//   cfg_* : apb registers, plane_width at 0x0, plane_height at 0x4; any write
//           restarts the plane; the user must write only while the decoder is
//           idle; the block itself does not enforce this
// sequencing: a control byte that starts raw data gives no pixel
//   a raw byte goes through the emit state and its pixel is presented from the
//   output register; each repeat pixel has a line store read, then an emit
//   a control byte with a repeat count of n holds the input until its repeats end
//   the single line store read port sets this order
// reset: plane restarts at line 0, width and height return to 64; line store
//   is not cleared as line 0 always writes it before a read value is used
// stall: the pixel output register holds while out_tready is low and the
//   sequencer waits with it; in_tready stays low until the byte is finished

module planar_rle_plane_decoder
  import prle_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] code_byte

  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [7:0] pixel_value, [18:8] column,
                                           // [30:19] buffer_row, [31] zero
  output logic                 out_tlast,  // run_last
  output logic                 out_tuser,  // plane_end

  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1) + 1;

  prle_state_t state_r, state_nxt;

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;

  logic [AW-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]    line_r, line_nxt;
  logic [PIX_W-1:0]    run_value_r, run_value_nxt;
  logic [RAW_W-1:0]    raw_left_r, raw_left_nxt;
  logic [REP_W-1:0]    rep_after_r, rep_after_nxt;
  logic [REP_W-1:0]    rep_cnt_r, rep_cnt_nxt;
  logic [CODE_W-1:0]   byte_r, byte_nxt;
  logic                is_raw_r, is_raw_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_pix_r, out_pix_nxt;
  logic [COL_OUT_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_pend_r, out_pend_nxt;

  logic [PIX_W-1:0]    line_store [MAX_WIDTH];
  logic [PIX_W-1:0]    rd_data_r;

  logic                cfg_wr;
  logic                in_fire;
  logic                out_free;
  logic                emit_fire;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WW-1:0]       col_inc;
  logic [HEIGHT_W-1:0] line_inc;
  logic                ended;
  logic                plane_done;
  logic                first_line;
  logic [PIX_W-1:0]    pix;
  logic [PIX_W-1:0]    raw_delta;
  logic                pix_last;
  logic [3:0]          lo_nib;
  logic [3:0]          hi_nib;
  logic                long_rep;
  logic [REP_W-1:0]    ctrl_rep;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {19'd0, height_r} : {20'd0, width_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign emit_fire  = (state_r == ST_EMIT) & out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_row_r, out_col_r, out_pix_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_pend_r;

  // effective geometry
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign col_inc    = WW'(col_r) + WW'(1);
  assign line_inc   = HEIGHT_W'(line_r) + HEIGHT_W'(1);
  assign ended      = (col_inc >= w_eff);
  assign plane_done = ended & (line_inc >= h_eff);
  assign first_line = (line_r == '0);

  // control byte decode
  assign lo_nib   = in_tdata[3:0];
  assign hi_nib   = in_tdata[7:4];
  assign long_rep = (lo_nib == LONG_REP_16) | (lo_nib == LONG_REP_32);
  assign ctrl_rep = long_rep ? {lo_nib[1:0], hi_nib} : {2'b00, lo_nib};

  assign raw_delta = first_line ? byte_r : delta_decode(byte_r);

  always_comb begin
    if (is_raw_r) begin
      pix = first_line ? byte_r : rd_data_r + raw_delta;
      pix_last = ended | ~((raw_left_r == RAW_W'(1)) & (rep_after_r != '0));
    end else begin
      pix = first_line ? run_value_r : rd_data_r + run_value_r;
      pix_last = ended | (rep_cnt_r == REP_W'(1));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    run_value_nxt = run_value_r;
    raw_left_nxt  = raw_left_r;
    rep_after_nxt = rep_after_r;
    rep_cnt_nxt   = rep_cnt_r;
    byte_nxt      = byte_r;
    is_raw_nxt    = is_raw_r;
    out_pix_nxt   = out_pix_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;
    out_pend_nxt  = out_pend_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_tdata;
          if (raw_left_r != '0) begin
            is_raw_nxt = 1'b1;
            state_nxt  = ST_EMIT;
          end else if (!long_rep && hi_nib != '0) begin
            raw_left_nxt  = hi_nib;
            rep_after_nxt = ctrl_rep;
          end else if (ctrl_rep != '0) begin
            is_raw_nxt  = 1'b0;
            rep_cnt_nxt = ctrl_rep;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = pix;
          out_col_nxt   = COL_OUT_W'(col_r);
          out_row_nxt   = ROW_W'(h_eff - HEIGHT_W'(1)) - line_r;
          out_last_nxt  = pix_last;
          out_pend_nxt  = plane_done;
          state_nxt     = pix_last ? ST_IDLE : ST_FETCH;
          if (is_raw_r) begin
            run_value_nxt = raw_delta;
            raw_left_nxt  = raw_left_r - RAW_W'(1);
            if (raw_left_r == RAW_W'(1)) begin
              rep_cnt_nxt   = rep_after_r;
              rep_after_nxt = '0;
              is_raw_nxt    = 1'b0;
            end
          end else begin
            rep_cnt_nxt = rep_cnt_r - REP_W'(1);
          end
          if (ended) begin
            col_nxt       = '0;
            run_value_nxt = '0;
            raw_left_nxt  = '0;
            rep_after_nxt = '0;
            line_nxt      = plane_done ? '0 : ROW_W'(line_inc);
          end else begin
            col_nxt = AW'(col_inc);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_HEIGHT) begin
        height_nxt = cfg_pwdata[HEIGHT_W-1:0];
      end else begin
        width_nxt = cfg_pwdata[WIDTH_W-1:0];
      end
      col_nxt       = '0;
      line_nxt      = '0;
      run_value_nxt = '0;
      raw_left_nxt  = '0;
      rep_after_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_W'(64);
      height_r    <= HEIGHT_W'(64);
      col_r       <= '0;
      line_r      <= '0;
      run_value_r <= '0;
      raw_left_r  <= '0;
      rep_after_r <= '0;
      rep_cnt_r   <= '0;
      is_raw_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      run_value_r <= run_value_nxt;
      raw_left_r  <= raw_left_nxt;
      rep_after_r <= rep_after_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      is_raw_r    <= is_raw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_pix_r  <= out_pix_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_last_r <= out_last_nxt;
    out_pend_r <= out_pend_nxt;
  end

  // line store: pixel above is read every cycle at the current column
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      line_store[col_r] <= pix;
    end
    rd_data_r <= line_store[col_r];
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r)
    else $error("emitted pixel not presented");

  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff)
    else $error("column beyond line width");

  a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pend_r) |-> out_last_r)
    else $error("plane end without run end");

  a_fetch_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> (rep_cnt_r != '0 && !is_raw_r))
    else $error("fetch without pending repeat");

endmodule

[bench/prle_checker.sv]
// prle_checker: watches the byte, pixel and register channels of the planar rle
// plane decoder, predicts each decoded pixel and compares it with the output item
// depends on prle_pkg

module prle_checker
  import prle_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] code_byte

  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // [7:0] pixel_value, [18:8] column, [30:19] buffer_row
  input  logic        out_tlast,   // run_last
  input  logic        out_tuser,   // plane_end

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,

  output int          fault_count,
  output int          pending,
  output int          pixel_count,
  output int          plane_count
);

  localparam int RESET_SIZE   = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0]     value;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_W-1:0]     row;
    logic                 run_last;
    logic                 plane_end;
  } pixel_t;

  pixel_t              predicted_pixels[$];
  logic [PIX_W-1:0]    line_mem [MAX_WIDTH];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int unsigned         col_pos;
  int unsigned         line_idx;
  logic [PIX_W-1:0]    run_val;
  logic [RAW_W-1:0]    raw_left;
  logic [REP_W-1:0]    rep_after;

  function automatic int unsigned line_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned plane_lines();
    if (height_reg == '0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_plane();
    col_pos   = 0;
    line_idx  = 0;
    run_val   = '0;
    raw_left  = '0;
    rep_after = '0;
  endfunction

  // one pixel; returns 1 when it closed a line
  function automatic bit put_pixel(input logic [PIX_W-1:0] v);
    int unsigned h;
    pixel_t      p;
    bit          ended;
    h     = plane_lines();
    ended = 1'b0;
    line_mem[col_pos] = v;
    p.value     = v;
    p.column    = COL_OUT_W'(col_pos);
    p.row       = ROW_W'(h - 1 - line_idx);
    p.run_last  = 1'b0;
    p.plane_end = 1'b0;
    col_pos++;
    if (col_pos >= line_width()) begin
      ended     = 1'b1;
      col_pos   = 0;
      run_val   = '0;
      raw_left  = '0;
      rep_after = '0;
      line_idx++;
      if (line_idx >= h) begin
        line_idx    = 0;
        p.plane_end = 1'b1;
      end
    end
    predicted_pixels.push_back(p);
    return ended;
  endfunction

  // repeats stop at the line end, the rest of the count is dropped
  function automatic void put_repeats(input int unsigned count);
    bit ended;
    ended = 1'b0;
    while (count > 0 && !ended) begin
      if (line_idx == 0) ended = put_pixel(run_val);
      else ended = put_pixel(PIX_W'(line_mem[col_pos] + run_val));
      count--;
    end
  endfunction

  function automatic void decode_code_byte(input logic [7:0] code);
    int unsigned      first;
    int unsigned      count;
    logic [3:0]       hi;
    logic [3:0]       lo;
    logic [PIX_W-1:0] delta;
    logic [PIX_W-1:0] v;
    bit               ended;
    pixel_t           tail;
    first = predicted_pixels.size();
    if (raw_left != '0) begin
      if (line_idx == 0) begin
        run_val = code;
        v       = code;
      end else begin
        // odd codes step down, even codes step up
        if (code[0]) delta = 8'd0 - {1'b0, code[7:1]} - 8'd1;
        else delta = {1'b0, code[7:1]};
        run_val = delta;
        v       = PIX_W'(line_mem[col_pos] + delta);
      end
      raw_left--;
      ended = put_pixel(v);
      if (!ended && raw_left == '0) begin
        count     = rep_after;
        rep_after = '0;
        put_repeats(count);
      end
    end else begin
      hi = code[7:4];
      lo = code[3:0];
      if (lo == LONG_REP_16 || lo == LONG_REP_32) begin
        put_repeats({lo, hi});
      end else if (hi != '0) begin
        raw_left  = hi;
        rep_after = REP_W'(lo);
      end else begin
        put_repeats(lo);
      end
    end
    if (predicted_pixels.size() > first) begin
      tail = predicted_pixels.pop_back();
      tail.run_last = 1'b1;
      predicted_pixels.push_back(tail);
    end
  endfunction

  function automatic void check_pixel();
    pixel_t got;
    pixel_t want;
    got = {out_tdata[7:0], out_tdata[18:8], out_tdata[30:19], out_tlast, out_tuser};
    pixel_count++;
    if (got.plane_end) plane_count++;
    if (predicted_pixels.size() == 0) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("unexpected pixel v=%02h c=%0d r=%0d l=%0b e=%0b",
                 got.value, got.column, got.row, got.run_last, got.plane_end);
    end else begin
      want = predicted_pixels.pop_front();
      if (got.value != want.value || got.column != want.column || got.row != want.row ||
          got.run_last != want.run_last || got.plane_end != want.plane_end) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display({"pixel mismatch exp v=%02h c=%0d r=%0d l=%0b e=%0b",
                    " got v=%02h c=%0d r=%0d l=%0b e=%0b"},
                   want.value, want.column, want.row, want.run_last, want.plane_end,
                   got.value, got.column, got.row, got.run_last, got.plane_end);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg   = WIDTH_W'(RESET_SIZE);
      height_reg  = HEIGHT_W'(RESET_SIZE);
      restart_plane();
      predicted_pixels.delete();
      fault_count = 0;
      pixel_count = 0;
      plane_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_WIDTH) width_reg = cfg_pwdata[WIDTH_W-1:0];
        else height_reg = cfg_pwdata[HEIGHT_W-1:0];
        restart_plane();
      end
      if (in_tvalid && in_tready) decode_code_byte(in_tdata);
      if (out_tvalid && out_tready) check_pixel();
    end
    pending = predicted_pixels.size();
  end

endmodule

[bench/tb_planar_rle_plane_decoder.sv]
// tb_planar_rle_plane_decoder: feeds directed and random compressed plane streams
// through the decoder under several plane sizes and idle patterns
// depends on prle_pkg, planar_rle_plane_decoder and prle_checker

module tb_planar_rle_plane_decoder;
  import prle_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] code_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [7:0] pixel_value, [18:8] column, [30:19] buffer_row
  logic        out_tlast;          // run_last
  logic        out_tuser;          // plane_end
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_count     = 0;
  int setting_count  = 0;
  int cycle_count    = 0;
  int fault_count;
  int pending;
  int pixel_count;
  int plane_count;

  planar_rle_plane_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  prle_checker pixel_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fault_count (fault_count),
    .pending     (pending),
    .pixel_count (pixel_count),
    .plane_count (plane_count)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_count++;
  endtask

  // drain every expected pixel, then let the sequencer go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // random bits above the register field
  function automatic logic [31:0] noisy(input int bits, input int unsigned value);
    return ($urandom() << bits) | value;
  endfunction

  task automatic set_plane(input int unsigned w, input int unsigned h);
    settle();
    cfg_write(ADDR_WIDTH, noisy(WIDTH_W, w));
    cfg_write(ADDR_HEIGHT, noisy(HEIGHT_W, h));
    setting_count++;
  endtask

  // one control byte, followed by its raw bytes when it announces any, or a lone random byte
  task automatic send_run(input int long_pct);
    int         pick;
    logic [3:0] hi;
    logic [3:0] lo;
    pick = $urandom_range(0, 99);
    if (pick < long_pct) begin
      hi = 4'($urandom());
      lo = $urandom_range(0, 1) ? LONG_REP_16 : LONG_REP_32;
      push_byte({hi, lo});
    end else if (pick < long_pct + 10) begin
      push_byte(8'($urandom()));
    end else begin
      hi = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 3));
      lo = 4'($urandom());
      push_byte({hi, lo});
      if (lo != LONG_REP_16 && lo != LONG_REP_32)
        repeat (hi) push_byte(8'($urandom()));
    end
  endtask

  task automatic run_phase(input int count, input int long_pct);
    int target;
    target = sent_count + count;
    while (sent_count < target) send_run(long_pct);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // small plane: empty byte, cut runs, downward and zero deltas, plane wrap
    set_plane(4, 3);
    push_byte(8'h00);
    push_byte(8'h31);
    push_byte(8'h20);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(8'h13);
    push_byte(8'h01);
    push_byte(8'hf2);
    push_byte(8'h14);
    push_byte(8'hab);
    push_byte(8'h0f);

    // zero sizes act as one pixel per plane
    set_plane(0, 0);
    push_byte(8'h21);
    push_byte(8'h10);
    push_byte(8'h7e);

    // oversize registers clamp to the largest plane
    set_plane(4095, 8191);
    push_byte(8'h02);
    push_byte(8'hf1);
    push_byte(8'h30);
    push_byte(8'h80);
    push_byte(8'h7f);
    push_byte(8'h55);

    // widest line, mostly long repeats, no idling
    set_plane(2048, 2);
    run_phase(100, 80);

    send_idle_pct = 88;
    set_plane($urandom_range(1, 24), $urandom_range(1, 6));
    run_phase(30, 25);
    settle();
    run_phase(30, 25);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    set_plane($urandom_range(1, 8), MAX_HEIGHT);
    run_phase(60, 25);

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    set_plane($urandom_range(2, 40), $urandom_range(1, 4));
    run_phase(60, 25);

    settle();
    $display("decoded %0d pixels from %0d code bytes over %0d plane sizes, %0d planes closed",
             pixel_count, sent_count, setting_count, plane_count);
    $display("widths 1 to 2048 and heights 1 to 4096 with free, idle and stalled channels");
    if (fault_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
src/prle_pkg.sv
src/planar_rle_plane_decoder.sv
bench/prle_checker.sv
bench/tb_planar_rle_plane_decoder.sv
